### design/assert_macros.svh
// assertion macros used by the tessellator top level
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### design/hgt_pkg.sv
// shared types and constants of the heightmap grid tessellator
// no dependencies
package hgt_pkg;
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_DEPTH = 1024;
	localparam int IDX_W = 20;
	localparam int COL_W = 12;
	localparam int ROW_W = 10;
	localparam int DIM_W = 13;
	localparam int CFG_W = 11;
	localparam int HGT_W = 8;
	localparam int HY_W = 12;
	localparam int TEX_W = 17;
	localparam int NRM_W = 16;
	localparam int DIV_NW = 46;
	localparam int DIV_DW = 18;
	localparam int CNT_W = 6;

	localparam logic CFG_GRID_WIDTH = 1'b0;
	localparam logic CFG_GRID_DEPTH = 1'b1;
	localparam logic KIND_VERTEX = 1'b0;
	localparam logic KIND_TRIANGLE = 1'b1;

	typedef struct packed {
		logic [IDX_W-1:0] vidx;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [HY_W-1:0]  hy;
		logic [HGT_W-1:0] h0;
		logic [HGT_W-1:0] h1;
		logic [HGT_W-1:0] h2;
		logic [HGT_W-1:0] h3;
		logic             quad;
		logic [DIM_W-1:0] wm1;
		logic [DIM_W-1:0] dm1;
	} job_t;
endpackage

### design/heightmap_grid_tessellator_top.sv
// top level of the heightmap grid tessellator
// depends on hgt_pkg, hgt_front, hgt_queue, hgt_back, assert_macros.svh
//
// Heights enter row-major, one per transfer; each sample gives a vertex
// result and, once a 2x2 quad is complete, two triangle results with unit
// face normals. The texture coordinates and normal components go through
// one shared restoring divider (one quotient bit per cycle) and the normal
// components also through a 16-step square root. The front takes the next
// sample once the line store read for it is registered and while the
// two-entry job queue has room. The line store is not cleared after reset.
module heightmap_grid_tessellator_top #(
	parameter int MAX_WIDTH = hgt_pkg::MAX_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [hgt_pkg::CFG_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [hgt_pkg::HGT_W-1:0] height,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      kind,
	output logic [hgt_pkg::IDX_W-1:0] first_index,
	output logic [hgt_pkg::IDX_W-1:0] second_index,
	output logic [hgt_pkg::IDX_W-1:0] third_index,
	output logic [hgt_pkg::HY_W-1:0]  height_y,
	output logic [hgt_pkg::TEX_W-1:0] tex_u,
	output logic [hgt_pkg::TEX_W-1:0] tex_v,
	output logic signed [hgt_pkg::NRM_W-1:0] normal_x,
	output logic signed [hgt_pkg::NRM_W-1:0] normal_y,
	output logic signed [hgt_pkg::NRM_W-1:0] normal_z,
	output logic                      last
);
	import hgt_pkg::*;
	`include "assert_macros.svh"

	job_t f_job, b_job;
	logic push, q_full, q_empty, pop;
	logic in_fire, vtx_out, tri_out, nrm_zero, vtx_zero;

	hgt_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .height,
		.q_full, .push, .job(f_job)
	);

	hgt_queue u_queue (
		.clk, .arst_n, .push, .din(f_job), .full(q_full),
		.pop, .dout(b_job), .empty(q_empty)
	);

	hgt_back u_back (
		.clk, .arst_n, .q_empty, .q_job(b_job), .pop,
		.out_valid, .out_stall, .kind, .first_index, .second_index,
		.third_index, .height_y, .tex_u, .tex_v,
		.normal_x, .normal_y, .normal_z, .last
	);

	assign in_fire = in_valid && !in_stall;
	assign vtx_out = out_valid && kind == KIND_VERTEX;
	assign tri_out = out_valid && kind == KIND_TRIANGLE;
	assign nrm_zero = normal_x == '0 && normal_y == '0 && normal_z == '0;
	assign vtx_zero = height_y == '0 && tex_u == '0 && tex_v == '0;

	`ASSERT_NEXT(a_in_gap, clk, arst_n, in_fire, in_stall, "stale line read")
	`ASSERT_IMPLIES(a_vtx_no_nrm, clk, arst_n, vtx_out, nrm_zero, "vertex with normal")
	`ASSERT_IMPLIES(a_tri_no_tex, clk, arst_n, tri_out, vtx_zero, "triangle with vertex data")
	`ASSERT_IMPLIES(a_no_overflow, clk, arst_n, push, !q_full, "job queue overflow")
endmodule

### design/hgt_front.sv
// front end: config registers, grid counters, line store, job build
// depends on hgt_pkg
module hgt_front #(
	parameter int MAX_WIDTH = hgt_pkg::MAX_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [hgt_pkg::CFG_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [hgt_pkg::HGT_W-1:0] height,
	input  logic                      q_full,
	output logic                      push,
	output hgt_pkg::job_t             job
);
	import hgt_pkg::*;

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic [CFG_W-1:0] width_q, depth_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [IDX_W-1:0] vtx_q;
	logic [HGT_W-1:0] left_q, ul_q, above_q;
	logic             rd_ok_q;
	logic [HGT_W-1:0] line_mem [MAX_WIDTH];
	logic [DIM_W-1:0] w_eff, d_eff;
	logic             accept, col_end, row_end;
	logic [14:0]      hy_x;
	logic [30:0]      hy_prod;

	always_comb begin
		if (width_q < CFG_W'(2)) w_eff = DIM_W'(2);
		else if (int'(width_q) > MAX_WIDTH) w_eff = DIM_W'(MAX_WIDTH);
		else w_eff = DIM_W'(width_q);
		if (depth_q < CFG_W'(2)) d_eff = DIM_W'(2);
		else if (int'(depth_q) > MAX_DEPTH) d_eff = DIM_W'(MAX_DEPTH);
		else d_eff = DIM_W'(depth_q);
	end

	// line store read is registered, so it lags the counter
	assign in_stall = !(rd_ok_q && !q_full);
	assign accept = in_valid && !in_stall;
	assign push = accept;
	assign col_end = (DIM_W'(col_q) + DIM_W'(1)) >= w_eff;
	assign row_end = (DIM_W'(row_q) + DIM_W'(1)) >= d_eff;

	// height * 64 / 5 rounded, via reciprocal multiply
	assign hy_x = {1'b0, height, 6'd0} + 15'd2;
	assign hy_prod = 31'(hy_x) * 31'd52429;

	always_comb begin
		job.vidx = vtx_q;
		job.col  = col_q;
		job.row  = row_q;
		job.hy   = hy_prod[29:18];
		job.h0   = ul_q;
		job.h1   = above_q;
		job.h2   = height;
		job.h3   = left_q;
		job.quad = (row_q != '0) && (col_q != '0);
		job.wm1  = w_eff - DIM_W'(1);
		job.dm1  = d_eff - DIM_W'(1);
	end

	always_ff @(posedge clk) begin
		if (accept) line_mem[col_q[AW-1:0]] <= height;
		above_q <= line_mem[col_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= CFG_W'(256);
			depth_q <= CFG_W'(256);
			col_q   <= '0;
			row_q   <= '0;
			vtx_q   <= '0;
			left_q  <= '0;
			ul_q    <= '0;
			rd_ok_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRID_WIDTH: width_q <= cfg_data;
				CFG_GRID_DEPTH: depth_q <= cfg_data;
				default: ;
			endcase
			col_q   <= '0;
			row_q   <= '0;
			vtx_q   <= '0;
			rd_ok_q <= 1'b0;
		end else if (accept) begin
			rd_ok_q <= 1'b0;
			left_q  <= height;
			ul_q    <= above_q;
			if (col_end) begin
				col_q <= '0;
				if (row_end) begin
					row_q <= '0;
					vtx_q <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
					vtx_q <= vtx_q + IDX_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
				vtx_q <= vtx_q + IDX_W'(1);
			end
		end else begin
			rd_ok_q <= 1'b1;
		end
	end
endmodule

### design/hgt_queue.sv
// two-entry job queue between front and back
// depends on hgt_pkg
module hgt_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hgt_pkg::job_t din,
	output logic          full,
	input  logic          pop,
	output hgt_pkg::job_t dout,
	output logic          empty
);
	import hgt_pkg::*;

	job_t       slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign dout = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end
endmodule

### design/hgt_back.sv
// back end: shared restoring divider and square root, result sequencing
// depends on hgt_pkg
module hgt_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_empty,
	input  hgt_pkg::job_t             q_job,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      kind,
	output logic [hgt_pkg::IDX_W-1:0] first_index,
	output logic [hgt_pkg::IDX_W-1:0] second_index,
	output logic [hgt_pkg::IDX_W-1:0] third_index,
	output logic [hgt_pkg::HY_W-1:0]  height_y,
	output logic [hgt_pkg::TEX_W-1:0] tex_u,
	output logic [hgt_pkg::TEX_W-1:0] tex_v,
	output logic signed [hgt_pkg::NRM_W-1:0] normal_x,
	output logic signed [hgt_pkg::NRM_W-1:0] normal_y,
	output logic signed [hgt_pkg::NRM_W-1:0] normal_z,
	output logic                      last
);
	import hgt_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LOAD = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_SQRT = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	// op codes: tex u, tex v, then x y z of each triangle normal
	localparam logic [2:0] OP_U = 3'd0, OP_V = 3'd1, OP_T1X = 3'd2, OP_T1Y = 3'd3,
		OP_T1Z = 3'd4, OP_T2X = 3'd5, OP_T2Y = 3'd6, OP_T2Z = 3'd7;

	state_t            st_q;
	job_t              job_q;
	logic [2:0]        op_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_NW-1:0] dnum_q;
	logic [DIV_DW-1:0] drem_q, dden_q;
	logic [31:0]       sq_num_q, sq_res_q, sq_bit_q;
	logic              neg_q;
	logic [TEX_W-1:0]  u_q, v_q;
	logic [NRM_W-1:0]  nx_q, ny_q, nz_q;

	logic signed [9:0] va, vc, comp;
	logic [7:0]        ma, mc, mcomp;
	logic [16:0]       s_sum;
	logic [15:0]       m2;
	logic [DIV_NW-1:0] ld_num;
	logic [DIV_DW-1:0] ld_den;
	logic [DIV_DW:0]   rs;
	logic              ge;
	logic [31:0]       sq_t;
	logic [14:0]       qmag;
	logic [NRM_W-1:0]  comp_val;
	logic [IDX_W-1:0]  base_idx;
	logic              out_free;

	// edge vectors, y component is fixed
	always_comb begin
		if (op_q < OP_T2X) begin
			va = $signed({2'b0, job_q.h0}) - $signed({2'b0, job_q.h1});
			vc = $signed({2'b0, job_q.h2}) - $signed({2'b0, job_q.h1});
		end else begin
			va = $signed({2'b0, job_q.h3}) - $signed({2'b0, job_q.h2});
			vc = $signed({2'b0, job_q.h3}) - $signed({2'b0, job_q.h0});
		end
		case (op_q)
			OP_T1X, OP_T2X: comp = va;
			OP_T1Z, OP_T2Z: comp = vc;
			default:        comp = 10'sd20;
		endcase
		ma = va[9] ? 8'(-va) : va[7:0];
		mc = vc[9] ? 8'(-vc) : vc[7:0];
		mcomp = comp[9] ? 8'(-comp) : comp[7:0];
		s_sum = (17'(ma) * 17'(ma)) + (17'(mc) * 17'(mc)) + 17'd400;
		m2 = 16'(mcomp) * 16'(mcomp);
		case (op_q)
			OP_U: begin
				ld_num = DIV_NW'({job_q.col, 17'd0}) + DIV_NW'(job_q.wm1);
				ld_den = DIV_DW'({job_q.wm1, 1'b0});
			end
			OP_V: begin
				ld_num = DIV_NW'({job_q.row, 17'd0}) + DIV_NW'(job_q.dm1);
				ld_den = DIV_DW'({job_q.dm1, 1'b0});
			end
			default: begin
				ld_num = {m2, 30'd0};
				ld_den = DIV_DW'(s_sum);
			end
		endcase
	end

	assign rs = {drem_q, dnum_q[DIV_NW-1]};
	assign ge = rs >= {1'b0, dden_q};
	assign sq_t = sq_res_q + sq_bit_q;
	assign qmag = 15'((sq_res_q + 32'd1) >> 1);
	assign comp_val = neg_q ? NRM_W'(-{1'b0, qmag}) : NRM_W'(qmag);
	assign base_idx = job_q.vidx - IDX_W'(job_q.wm1) - IDX_W'(2);
	assign out_free = !out_valid || !out_stall;
	assign pop = (st_q == ST_IDLE) && !q_empty;

	always_ff @(posedge clk) begin
		if (pop) job_q <= q_job;
		case (st_q)
			ST_LOAD: begin
				dnum_q <= ld_num;
				drem_q <= '0;
				dden_q <= ld_den;
				neg_q  <= comp[9];
			end
			ST_DIV: begin
				if (cnt_q != '0) begin
					drem_q <= ge ? DIV_DW'(rs - {1'b0, dden_q}) : rs[DIV_DW-1:0];
					dnum_q <= {dnum_q[DIV_NW-2:0], ge};
				end else if (op_q == OP_U) begin
					u_q <= dnum_q[TEX_W-1:0];
				end else if (op_q == OP_V) begin
					v_q <= dnum_q[TEX_W-1:0];
				end else begin
					sq_num_q <= dnum_q[31:0];
					sq_res_q <= '0;
					sq_bit_q <= 32'd1 << 30;
				end
			end
			ST_SQRT: begin
				if (cnt_q != '0) begin
					if (sq_num_q >= sq_t) begin
						sq_num_q <= sq_num_q - sq_t;
						sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
					end else begin
						sq_res_q <= sq_res_q >> 1;
					end
					sq_bit_q <= sq_bit_q >> 2;
				end else begin
					case (op_q)
						OP_T1X, OP_T2X: nx_q <= comp_val;
						OP_T1Y, OP_T2Y: ny_q <= comp_val;
						default:        nz_q <= comp_val;
					endcase
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					if (op_q == OP_V) begin
						kind         <= KIND_VERTEX;
						first_index  <= job_q.vidx;
						second_index <= '0;
						third_index  <= '0;
						height_y     <= job_q.hy;
						tex_u        <= u_q;
						tex_v        <= v_q;
						normal_x     <= '0;
						normal_y     <= '0;
						normal_z     <= '0;
						last         <= !job_q.quad;
					end else begin
						kind         <= KIND_TRIANGLE;
						first_index  <= base_idx;
						height_y     <= '0;
						tex_u        <= '0;
						tex_v        <= '0;
						normal_x     <= nx_q;
						normal_y     <= ny_q;
						normal_z     <= nz_q;
						if (op_q == OP_T1Z) begin
							second_index <= base_idx + IDX_W'(1);
							third_index  <= job_q.vidx;
							last         <= 1'b0;
						end else begin
							second_index <= job_q.vidx;
							third_index  <= job_q.vidx - IDX_W'(1);
							last         <= 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			op_q      <= OP_U;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (st_q == ST_EMIT && out_free) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (!q_empty) begin
						op_q <= OP_U;
						st_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					cnt_q <= CNT_W'(DIV_NW);
					st_q  <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - CNT_W'(1);
					end else if (op_q == OP_U) begin
						op_q <= OP_V;
						st_q <= ST_LOAD;
					end else if (op_q == OP_V) begin
						st_q <= ST_EMIT;
					end else begin
						cnt_q <= CNT_W'(16);
						st_q  <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - CNT_W'(1);
					end else if (op_q == OP_T1Z || op_q == OP_T2Z) begin
						st_q <= ST_EMIT;
					end else begin
						op_q <= op_q + 3'd1;
						st_q <= ST_LOAD;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if ((op_q == OP_V && job_q.quad) || op_q == OP_T1Z) begin
							op_q <= op_q + 3'd1;
							st_q <= ST_LOAD;
						end else begin
							st_q <= ST_IDLE;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
